[rtl/tsi_pkg.sv]
// ----------------------------------------------------------------------------
// tsi_pkg
// Types and constants shared by the timestamped sample interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned ANG_W   = 16;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] LANE_X     = 3'd0;
    localparam logic [2:0] LANE_Y     = 3'd1;
    localparam logic [2:0] LANE_Z     = 3'd2;
    localparam logic [2:0] LANE_PITCH = 3'd3;
    localparam logic [2:0] LANE_YAW   = 3'd4;
    localparam logic [2:0] LANE_ROLL  = 3'd5;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

    typedef struct packed {
        logic [ANG_W-1:0] roll;
        logic [ANG_W-1:0] yaw;
        logic [ANG_W-1:0] pitch;
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } t_pose;

    localparam int unsigned POSE_W = $bits(t_pose);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_DIV,
        S_RDA,
        S_RDB,
        S_LATB,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage

[rtl/tsi_ram.sv]
// ----------------------------------------------------------------------------
// tsi_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tsi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tsi_div.sv]
// ----------------------------------------------------------------------------
// tsi_div
// Restoring divider for the interpolation weight: one quotient bit a cycle,
// giving floor(num * 2^16 / den) for num below den.
// ----------------------------------------------------------------------------
module tsi_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tsi_pkg::TIME_W-1:0]     i_num,
    input  logic [tsi_pkg::TIME_W-1:0]     i_den,
    output logic                           o_busy,
    output logic [tsi_pkg::ALPHA_W-1:0]    o_quot
);

    logic [tsi_pkg::TIME_W-1:0]          r_rem, n_rem;
    logic [tsi_pkg::TIME_W-1:0]          r_den;
    logic [tsi_pkg::ALPHA_W-1:0]         r_quot, n_quot;
    logic [$clog2(tsi_pkg::ALPHA_W)-1:0] r_cnt;
    logic                                r_busy;
    logic [tsi_pkg::TIME_W:0]            w_rem2;
    logic [tsi_pkg::TIME_W:0]            w_sub;

    always_comb begin
        w_rem2 = {r_rem, 1'b0};
        w_sub  = w_rem2 - {1'b0, r_den};
        if (w_rem2 >= {1'b0, r_den}) begin
            n_rem  = w_sub[tsi_pkg::TIME_W-1:0];
            n_quot = {r_quot[tsi_pkg::ALPHA_W-2:0], 1'b1};
        end else begin
            n_rem  = w_rem2[tsi_pkg::TIME_W-1:0];
            n_quot = {r_quot[tsi_pkg::ALPHA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

[rtl/timestamped_sample_interpolator.sv]
// A push, a clear or an ignored beat is handled as it is accepted; a tick on a ring
// that is not empty runs a scan of the time memory at one entry a cycle, sixteen
// divider steps when a weight has to be computed, reads of the two pose samples and
// a multiply and an add per channel on the shared multiplier. One item is handled at
// a time; the next is taken while a result still waits on the output.
// Reset (synchronous, active low) empties the ring and sets the delay to 100 ms.
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator
// Ring of timestamped poses with linear interpolation at render time.
// ----------------------------------------------------------------------------
module timestamped_sample_interpolator #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_ms, pos_x, pos_y, pos_z, rot_pitch, rot_yaw, rot_roll
    input  logic [175:0] s_axis_tdata,
    // mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, out_pitch, out_yaw, out_roll
    output logic [143:0] m_axis_tdata
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned TW = tsi_pkg::TIME_W;
    localparam logic [CW-1:0] FULL  = CW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LASTS = AW'(BUFFER_DEPTH - 1);

    tsi_pkg::t_state r_state, n_state;

    logic [tsi_pkg::DELAY_W-1:0] r_delay;
    logic [CW-1:0]  r_fill;
    logic [AW-1:0]  r_wslot;
    logic [TW-1:0]  r_rt;
    logic [CW-1:0]  r_idx;
    logic           r_cv;
    logic [AW-1:0]  r_ci;
    logic           r_ho, r_hn;
    logic [AW-1:0]  r_io, r_in;
    logic [TW-1:0]  r_to, r_tn;
    logic [AW-1:0]  r_a_idx, r_b_idx;
    logic [tsi_pkg::ALPHA_W-1:0] r_alpha;
    tsi_pkg::t_pose r_a, r_b, r_res, r_out;
    logic [2:0]     r_lane;
    logic signed [49:0] r_prod;
    logic           r_ov;

    logic           w_acc;
    logic [1:0]     w_mode;
    logic [TW-1:0]  w_time;
    logic           w_push;
    logic [AW-1:0]  w_slot;
    logic [TW-1:0]  w_t_rd;
    tsi_pkg::t_pose w_p_rd;
    logic [AW-1:0]  w_t_raddr, w_p_raddr;
    logic           w_div_start, w_div_busy;
    logic [tsi_pkg::ALPHA_W-1:0] w_quot;
    logic [TW-1:0]  w_diff, w_dt;
    logic [CW-1:0]  w_last;
    logic signed [32:0] w_d;
    logic [TW-1:0]  w_sel_a;
    logic [15:0]    w_ang;

    assign w_mode = s_axis_tuser;
    assign w_time = s_axis_tdata[31:0];
    assign s_axis_tready = (r_state == tsi_pkg::S_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_push = w_acc && (w_mode == tsi_pkg::MODE_PUSH);
    assign w_slot = (r_fill < FULL) ? r_fill[AW-1:0] : r_wslot;
    assign w_last = r_fill - 1'b1;
    assign w_diff = r_rt - r_to;
    assign w_dt   = r_tn - r_to;
    assign w_t_raddr = r_idx[AW-1:0];
    assign w_p_raddr = (r_state == tsi_pkg::S_RDB) ? r_b_idx : r_a_idx;
    assign w_div_start = (r_state == tsi_pkg::S_DEC) && r_ho && r_hn && (r_io != r_in)
                         && (r_tn > r_to) && (w_diff != w_dt);

    tsi_ram #(.WIDTH(TW), .DEPTH(BUFFER_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (w_slot),
        .i_wdata (w_time),
        .i_raddr (w_t_raddr),
        .o_rdata (w_t_rd)
    );

    tsi_ram #(.WIDTH(tsi_pkg::POSE_W), .DEPTH(BUFFER_DEPTH)) u_pose_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (w_slot),
        .i_wdata (s_axis_tdata[175:32]),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rd)
    );

    tsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_diff),
        .i_den   (w_dt),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_d     = '0;
        w_sel_a = '0;
        w_ang   = '0;
        case (r_lane)
            tsi_pkg::LANE_X: begin
                w_d     = {r_b.x[31], r_b.x} - {r_a.x[31], r_a.x};
                w_sel_a = r_a.x;
            end
            tsi_pkg::LANE_Y: begin
                w_d     = {r_b.y[31], r_b.y} - {r_a.y[31], r_a.y};
                w_sel_a = r_a.y;
            end
            tsi_pkg::LANE_Z: begin
                w_d     = {r_b.z[31], r_b.z} - {r_a.z[31], r_a.z};
                w_sel_a = r_a.z;
            end
            tsi_pkg::LANE_PITCH: begin
                w_ang   = r_b.pitch - r_a.pitch;
                w_d     = {{17{w_ang[15]}}, w_ang};
                w_sel_a = {16'd0, r_a.pitch};
            end
            tsi_pkg::LANE_YAW: begin
                w_ang   = r_b.yaw - r_a.yaw;
                w_d     = {{17{w_ang[15]}}, w_ang};
                w_sel_a = {16'd0, r_a.yaw};
            end
            tsi_pkg::LANE_ROLL: begin
                w_ang   = r_b.roll - r_a.roll;
                w_d     = {{17{w_ang[15]}}, w_ang};
                w_sel_a = {16'd0, r_a.roll};
            end
            default: begin
                w_d     = '0;
                w_sel_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsi_pkg::S_IDLE: begin
                if (w_acc && (w_mode == tsi_pkg::MODE_TICK) && (r_fill != '0)) begin
                    n_state = tsi_pkg::S_SCAN;
                end
            end
            tsi_pkg::S_SCAN: begin
                if (r_cv && (r_ci == w_last[AW-1:0])) begin
                    n_state = tsi_pkg::S_DEC;
                end
            end
            tsi_pkg::S_DEC: begin
                n_state = w_div_start ? tsi_pkg::S_DIV : tsi_pkg::S_RDA;
            end
            tsi_pkg::S_DIV: begin
                if (!w_div_busy) begin
                    n_state = tsi_pkg::S_RDA;
                end
            end
            tsi_pkg::S_RDA:  n_state = tsi_pkg::S_RDB;
            tsi_pkg::S_RDB:  n_state = tsi_pkg::S_LATB;
            tsi_pkg::S_LATB: n_state = tsi_pkg::S_MUL;
            tsi_pkg::S_MUL:  n_state = tsi_pkg::S_ADD;
            tsi_pkg::S_ADD: begin
                n_state = (r_lane == tsi_pkg::LANE_ROLL) ? tsi_pkg::S_DONE : tsi_pkg::S_MUL;
            end
            tsi_pkg::S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_state = tsi_pkg::S_IDLE;
                end
            end
            default: n_state = tsi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsi_pkg::S_IDLE;
            r_delay <= tsi_pkg::DELAY_RESET;
            r_fill  <= '0;
            r_wslot <= '0;
            r_ov    <= 1'b0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (w_acc && (w_mode == tsi_pkg::MODE_CLEAR)) begin
                r_fill  <= '0;
                r_wslot <= '0;
            end else if (w_push) begin
                if (r_fill < FULL) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_wslot <= (r_wslot == LASTS) ? '0 : r_wslot + 1'b1;
                end
            end
            r_cv <= (r_state == tsi_pkg::S_SCAN) && (r_idx < r_fill);
            if ((r_state == tsi_pkg::S_DONE) && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tsi_pkg::S_IDLE: begin
                r_rt   <= (w_time >= TW'(r_delay)) ? w_time - TW'(r_delay) : '0;
                r_idx  <= '0;
                r_ho   <= 1'b0;
                r_hn   <= 1'b0;
                r_lane <= tsi_pkg::LANE_X;
            end
            tsi_pkg::S_SCAN: begin
                if (r_idx < r_fill) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_ci <= r_idx[AW-1:0];
                if (r_cv) begin
                    if ((w_t_rd <= r_rt) && (!r_ho || (w_t_rd > r_to))) begin
                        r_ho <= 1'b1;
                        r_io <= r_ci;
                        r_to <= w_t_rd;
                    end
                    if ((w_t_rd >= r_rt) && (!r_hn || (w_t_rd < r_tn))) begin
                        r_hn <= 1'b1;
                        r_in <= r_ci;
                        r_tn <= w_t_rd;
                    end
                end
            end
            tsi_pkg::S_DEC: begin
                if (r_ho && r_hn && (r_io != r_in) && (r_tn > r_to)) begin
                    r_a_idx <= r_io;
                    r_b_idx <= r_in;
                    r_alpha <= '1;
                end else begin
                    r_a_idx <= r_hn ? r_in : r_io;
                    r_b_idx <= r_hn ? r_in : r_io;
                    r_alpha <= '0;
                end
            end
            tsi_pkg::S_DIV: begin
                if (!w_div_busy) begin
                    r_alpha <= w_quot;
                end
            end
            tsi_pkg::S_RDB: r_a <= w_p_rd;
            tsi_pkg::S_LATB: r_b <= w_p_rd;
            tsi_pkg::S_MUL: begin
                r_prod <= w_d * $signed({1'b0, r_alpha});
            end
            tsi_pkg::S_ADD: begin
                case (r_lane)
                    tsi_pkg::LANE_X:     r_res.x     <= w_sel_a + r_prod[47:16];
                    tsi_pkg::LANE_Y:     r_res.y     <= w_sel_a + r_prod[47:16];
                    tsi_pkg::LANE_Z:     r_res.z     <= w_sel_a + r_prod[47:16];
                    tsi_pkg::LANE_PITCH: r_res.pitch <= w_sel_a[15:0] + r_prod[31:16];
                    tsi_pkg::LANE_YAW:   r_res.yaw   <= w_sel_a[15:0] + r_prod[31:16];
                    tsi_pkg::LANE_ROLL:  r_res.roll  <= w_sel_a[15:0] + r_prod[31:16];
                    default:             r_res       <= r_res;
                endcase
                r_lane <= r_lane + 1'b1;
            end
            tsi_pkg::S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_lane <= r_lane;
            end
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count above ring depth");
    a_wslot_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wslot != '0) |-> (r_fill == FULL))
        else $error("overwrite slot moved before ring was full");
    a_single_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsi_pkg::S_MUL && r_a_idx == r_b_idx) |-> (r_alpha == '0))
        else $error("non-zero weight for a single sample");
    a_lane_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsi_pkg::S_ADD) |-> (r_lane <= tsi_pkg::LANE_ROLL))
        else $error("lerp lane out of range");
`endif

endmodule

[bench/tb_timestamped_sample_interpolator.sv]
// ----------------------------------------------------------------------------
// tb_timestamped_sample_interpolator
// Self-checking bench for the timestamped sample interpolator. A directed
// table of pushes, ticks and clears runs first, followed by random traffic
// under several idling phases, with every output beat compared against a
// behavioural model of the pose ring.
// ----------------------------------------------------------------------------
module tb_timestamped_sample_interpolator;

    localparam int DEPTH = 16;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] t;
        logic [31:0] x, y, z;
        logic [15:0] p, yw, r;
        bit          has_exp;
        logic [143:0] exp_data;
    } t_row;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [15:0]  i_cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = 0;
    logic [1:0]   s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;

    timestamped_sample_interpolator #(.BUFFER_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    logic [31:0] ring_time [DEPTH];
    logic [31:0] ring_x [DEPTH], ring_y [DEPTH], ring_z [DEPTH];
    logic [15:0] ring_p [DEPTH], ring_yw [DEPTH], ring_r [DEPTH];
    int          ring_fill, ring_wr;
    logic [15:0] delay_ms;

    logic [143:0] pose_queue [$];
    int  errors = 0;
    int  send_idle = 0, recv_stall = 0;
    bit  hold_off = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("timestamped_sample_interpolator verification failed");
        $finish;
    end

    function automatic longint floor16(longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic logic [31:0] blend_pos(logic [31:0] a, logic [31:0] b, longint al);
        longint d;
        d = longint'($signed(b)) - longint'($signed(a));
        return 32'(longint'($signed(a)) + floor16(d * al));
    endfunction

    function automatic logic [15:0] blend_ang(logic [15:0] a, logic [15:0] b, longint al);
        logic [15:0] du;
        du = b - a;
        return a + 16'(floor16(longint'($signed(du)) * al));
    endfunction

    function automatic void apply_item(t_row it);
        logic [31:0] rt;
        bit ho, hn;
        int io, inw, pk, sl;
        longint unsigned num, al;
        logic [31:0] dt;
        if (it.mode == tsi_pkg::MODE_CLEAR) begin
            ring_fill = 0;
            ring_wr = 0;
        end else if (it.mode == tsi_pkg::MODE_PUSH) begin
            if (ring_fill < DEPTH) begin
                sl = ring_fill;
                ring_fill++;
            end else begin
                sl = ring_wr;
                ring_wr = (sl + 1) % DEPTH;
            end
            ring_time[sl] = it.t;
            ring_x[sl] = it.x; ring_y[sl] = it.y; ring_z[sl] = it.z;
            ring_p[sl] = it.p; ring_yw[sl] = it.yw; ring_r[sl] = it.r;
        end else if (it.mode == tsi_pkg::MODE_TICK && ring_fill != 0) begin
            rt = (it.t >= delay_ms) ? it.t - delay_ms : 0;
            ho = 0; hn = 0; io = 0; inw = 0;
            for (int i = 0; i < ring_fill; i++) begin
                if (ring_time[i] <= rt && (!ho || ring_time[i] > ring_time[io])) begin
                    io = i; ho = 1;
                end
                if (ring_time[i] >= rt && (!hn || ring_time[i] < ring_time[inw])) begin
                    inw = i; hn = 1;
                end
            end
            if (ho && hn && io != inw && ring_time[inw] > ring_time[io]) begin
                dt = ring_time[inw] - ring_time[io];
                num = longint'(rt - ring_time[io]) << 16;
                al = num / dt;
                if (al > 65535) al = 65535;
                pose_queue.push_back({
                    blend_ang(ring_r[io], ring_r[inw], al),
                    blend_ang(ring_yw[io], ring_yw[inw], al),
                    blend_ang(ring_p[io], ring_p[inw], al),
                    blend_pos(ring_z[io], ring_z[inw], al),
                    blend_pos(ring_y[io], ring_y[inw], al),
                    blend_pos(ring_x[io], ring_x[inw], al)});
            end else begin
                pk = (ho && hn) ? inw : (ho ? io : inw);
                pose_queue.push_back({ring_r[pk], ring_yw[pk], ring_p[pk],
                                      ring_z[pk], ring_y[pk], ring_x[pk]});
            end
        end
    endfunction

    task automatic send_item(t_row it);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= it.mode;
        s_axis_tdata <= {it.r, it.yw, it.p, it.z, it.y, it.x, it.t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_item(it);
        if (it.has_exp && pose_queue.size() > 0 && pose_queue[$] != it.exp_data) begin
            $display("%0t table entry expected %h model %h", $time, it.exp_data, pose_queue[$]);
            errors++;
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 0;
        while (pose_queue.size() > 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_delay(logic [15:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        delay_ms = v;
        @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [1:0] m, logic [31:0] t, logic [31:0] x,
                                logic [15:0] a);
        t_row it;
        it.mode = m; it.t = t; it.x = x; it.y = ~x; it.z = x ^ 32'h5A5A_0F0F;
        it.p = a; it.yw = ~a; it.r = a + 16'h4000;
        it.has_exp = 0; it.exp_data = '0;
        return it;
    endfunction

    function automatic t_row rand_item(int base, int sp);
        t_row it;
        int k;
        k = $urandom_range(99);
        it = mk(tsi_pkg::MODE_PUSH, base + $urandom_range(sp), $urandom, 16'($urandom));
        it.y = $urandom; it.z = $urandom; it.yw = 16'($urandom); it.r = 16'($urandom);
        if (k < 3) it.t = $urandom;
        if (k < 50) it.mode = tsi_pkg::MODE_PUSH;
        else if (k < 93) it.mode = tsi_pkg::MODE_TICK;
        else if (k < 97) it.mode = tsi_pkg::MODE_CLEAR;
        else it.mode = tsi_pkg::MODE_UNUSED;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pose_queue.size() == 0) begin
                $display("%0t unexpected beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                if (pose_queue[0] != m_axis_tdata) begin
                    $display("%0t mismatch expected %h actual %h",
                             $time, pose_queue[0], m_axis_tdata);
                    errors++;
                end
                void'(pose_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) m_axis_tready <= 0;
        else m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    initial begin
        t_row tab [$];
        t_row it;
        int base, cnt;
        ring_fill = 0; ring_wr = 0; delay_ms = tsi_pkg::DELAY_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        it = mk(tsi_pkg::MODE_TICK, 500, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 1000, 32'h7FFF_FFFF, 16'h7FFF); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 0, 0, 0); it.has_exp = 1;
        it.exp_data = {16'hBFFF, 16'h8000, 16'h7FFF, 32'h25A5_F0F0,
                       32'h8000_0000, 32'h7FFF_FFFF};
        tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 2000, 32'h8000_0000, 16'h8000); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 1600, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 2100, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 32'hFFFF_FFFF, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 2000, 32'h0000_0100, 16'h0001); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 2100, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 1000, 32'h1234_5678, 16'h0101); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 1100, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 1150, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_UNUSED, 1150, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_CLEAR, 0, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 1150, 0, 0); tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 0, 32'hFFFF_FF00, 16'h7000); tab.push_back(it);
        it = mk(tsi_pkg::MODE_PUSH, 32'hFFFF_FFFF, 32'h0000_0300, 16'h9000);
        tab.push_back(it);
        it = mk(tsi_pkg::MODE_TICK, 32'h8000_0000, 0, 0); tab.push_back(it);
        for (int i = 0; i < 18; i++) begin
            it = mk(tsi_pkg::MODE_PUSH, 100 * i, $urandom, 16'($urandom));
            tab.push_back(it);
        end
        it = mk(tsi_pkg::MODE_TICK, 950, 0, 0); tab.push_back(it);
        foreach (tab[i]) send_item(tab[i]);

        set_delay(16'd0);
        it = mk(tsi_pkg::MODE_TICK, 1234, 0, 0); send_item(it);
        set_delay(16'hFFFF);
        it = mk(tsi_pkg::MODE_TICK, 1234, 0, 0); send_item(it);
        set_delay(16'd100);

        base = 10000;
        cnt = 0;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 74; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 74; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            if (ph == 4) set_delay(16'd0);
            if (ph == 5) set_delay(16'hFFFF);
            if (ph == 6) set_delay(16'($urandom));
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 200; n++) begin
                it = rand_item(base, 400);
                if (it.mode == tsi_pkg::MODE_PUSH) base += $urandom_range(40);
                if (ph == 5) it.t = it.t + 70000;
                send_item(it);
                cnt++;
            end
        end

        send_idle = 0; recv_stall = 0;
        drain();
        if (pose_queue.size() != 0) begin
            $display("%0t %0d expected beats never arrived", $time, pose_queue.size());
            errors++;
        end
        if (errors == 0)
            $display("timestamped_sample_interpolator verification clean");
        else
            $display("timestamped_sample_interpolator verification failed");
        $finish;
    end
endmodule
